>>> design/sspp_pkg.sv
// Shared types and constants for the servo status packet parser.
package sspp_pkg;

    localparam int ID_SLOTS   = 4;
    localparam int MAX_MOTORS = 4;
    localparam int SLOT_LIMIT = (MAX_MOTORS < ID_SLOTS) ? MAX_MOTORS : ID_SLOTS;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] IDLE_BYTE   = 8'h00;
    localparam logic [7:0] LEN_VALUE   = 8'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_ARM  = 1'b1;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_CHKSUM  = 2'd1;
    localparam logic [1:0] RES_UNKNOWN = 2'd2;
    localparam logic [1:0] RES_LOST    = 2'd3;

    localparam logic [2:0] REG_MOTOR_COUNT = 3'd0;
    localparam logic [2:0] REG_MOTOR_ID_0  = 3'd1;
    localparam logic [2:0] REG_MOTOR_ID_1  = 3'd2;
    localparam logic [2:0] REG_MOTOR_ID_2  = 3'd3;
    localparam logic [2:0] REG_MOTOR_ID_3  = 3'd4;

    typedef struct packed {
        logic [7:0]  motor_error;
        logic [15:0] position;
        logic [7:0]  motor_id;
        logic [1:0]  motor_index;
        logic [1:0]  status;
    } result_t;

    typedef logic [ID_SLOTS-1:0][7:0] id_table_t;

endpackage

>>> design/sspp_parser.sv
// Byte-wise status packet state machine, checksum and id lookup.
module sspp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                kind,
    input  logic [7:0]          data_byte,
    input  logic [2:0]          motor_count,
    input  sspp_pkg::id_table_t motor_ids,
    output logic                res_valid,
    output sspp_pkg::result_t   res
);

    typedef enum logic [9:0] {
        S_READY   = 10'b00_0000_0001,
        S_HEAD1   = 10'b00_0000_0010,
        S_HEAD2   = 10'b00_0000_0100,
        S_GOT_ID  = 10'b00_0000_1000,
        S_GOT_LEN = 10'b00_0001_0000,
        S_GOT_ERR = 10'b00_0010_0000,
        S_GOT_P1  = 10'b00_0100_0000,
        S_GOT_P2  = 10'b00_1000_0000,
        S_DONE    = 10'b01_0000_0000,
        S_LOST    = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] err_reg, err_next;
    logic [7:0] p1_reg, p1_next;
    logic [7:0] p2_reg, p2_next;

    logic [7:0] sum;
    logic [2:0] slot_limit;
    logic       hit;
    logic [1:0] hit_index;

    assign sum = id_reg + sspp_pkg::LEN_VALUE + err_reg + p1_reg + p2_reg;

    always_comb
    begin
        slot_limit = (motor_count > 3'(sspp_pkg::SLOT_LIMIT)) ? 3'(sspp_pkg::SLOT_LIMIT)
                                                              : motor_count;
        hit       = 1'b0;
        hit_index = '0;
        for (int i = sspp_pkg::ID_SLOTS - 1; i >= 0; i--)
        begin
            if ((3'(i) < slot_limit) && (motor_ids[i] == id_reg))
            begin
                hit       = 1'b1;
                hit_index = 2'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        err_next   = err_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (accept)
        begin
            if (kind == sspp_pkg::KIND_ARM)
            begin
                state_next = S_READY;
            end
            else
            begin
                unique case (state_reg)
                    S_READY:
                    begin
                        if (data_byte == sspp_pkg::HEADER_BYTE)
                            state_next = S_HEAD1;
                        else if (data_byte != sspp_pkg::IDLE_BYTE)
                            state_next = S_LOST;
                    end
                    S_HEAD1:
                    begin
                        if (data_byte == sspp_pkg::HEADER_BYTE)
                            state_next = S_HEAD2;
                        else
                        begin
                            id_next    = data_byte;
                            state_next = S_GOT_ID;
                        end
                    end
                    S_HEAD2:
                    begin
                        id_next    = data_byte;
                        state_next = S_GOT_ID;
                    end
                    S_GOT_ID:
                    begin
                        state_next = (data_byte == sspp_pkg::LEN_VALUE) ? S_GOT_LEN : S_LOST;
                    end
                    S_GOT_LEN:
                    begin
                        err_next   = data_byte;
                        state_next = S_GOT_ERR;
                    end
                    S_GOT_ERR:
                    begin
                        p1_next    = data_byte;
                        state_next = S_GOT_P1;
                    end
                    S_GOT_P1:
                    begin
                        p2_next    = data_byte;
                        state_next = S_GOT_P2;
                    end
                    S_GOT_P2:
                    begin
                        state_next      = S_DONE;
                        res_valid       = 1'b1;
                        res.motor_id    = id_reg;
                        res.motor_error = err_reg;
                        res.position    = {p2_reg, p1_reg};
                        if (~sum != data_byte)
                            res.status = sspp_pkg::RES_CHKSUM;
                        else if (hit)
                        begin
                            res.status      = sspp_pkg::RES_OK;
                            res.motor_index = hit_index;
                        end
                        else
                            res.status = sspp_pkg::RES_UNKNOWN;
                    end
                    S_LOST:
                    begin
                        state_next = S_DONE;
                        res_valid  = 1'b1;
                        res.status = sspp_pkg::RES_LOST;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_READY;
            id_reg    <= '0;
            err_reg   <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            id_reg    <= id_next;
            err_reg   <= err_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
        end
    end

    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (state_reg == S_GOT_P2 || state_reg == S_LOST))
        else $error("result from a state that cannot end a packet");

    a_index_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != sspp_pkg::RES_OK) |-> (res.motor_index == 2'd0))
        else $error("slot index set on a failed packet");

    a_arm_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == sspp_pkg::KIND_ARM) |=> (state_reg == S_READY))
        else $error("arm did not return parser to ready");

endmodule

>>> design/sspp_obuf.sv
// Two-entry result buffer: output register plus skid stage.
module sspp_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sspp_pkg::result_t push_data,
    output logic              can_accept,
    output logic              out_valid,
    input  logic              out_ready,
    output sspp_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    sspp_pkg::result_t out_reg, out_next;
    sspp_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop        = out_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg)
        begin
            if (pop && push)
                out_next = push_data;
            else if (pop)
                out_valid_next = 1'b0;
            else if (push)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && push))
        else $error("skid filled while output was free");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pop) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid entry lost or overwritten");

endmodule

>>> design/servo_status_packet_parser_core.sv
// Top level of the servo status packet parser with its register block.
//
// Input stream (s_axis_*): one item per received byte, or an arm item
// (tuser = 1) that returns the parser to waiting for a new reply.
// Output stream (m_axis_*): one result per finished reply, or one "lost"
// result on the first byte after the parser lost framing.
// The APB port holds motor_count at 0x00 and motor ids 0..3 at 0x04..0x10.
//
// A result is registered into the output buffer as the checksum byte (or the
// lost byte) is taken. Throughput: one item per cycle while s_axis_tready
// is high. State machine, checksum adder, four id compares: all combinational.
// A two-entry output buffer lets items keep flowing while a result waits;
// s_axis_tready drops only when both entries are full, and rises again once
// one is taken.
// Reset clears the registers to zero, the id table to zero and the parser
// to ready; nothing is emitted before a reply ends or framing is lost.
module servo_status_packet_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] motor_index, [9:2] motor_id,
                                        // [25:10] position, [33:26] motor_error
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic [2:0]          motor_count_reg;
    sspp_pkg::id_table_t motor_ids_reg;
    logic                cfg_write;
    logic [2:0]          reg_index;

    logic                accept;
    logic                res_valid;
    sspp_pkg::result_t   res;
    sspp_pkg::result_t   out_data;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_count_reg <= '0;
            motor_ids_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                sspp_pkg::REG_MOTOR_COUNT: motor_count_reg  <= pwdata[2:0];
                sspp_pkg::REG_MOTOR_ID_0:  motor_ids_reg[0] <= pwdata[7:0];
                sspp_pkg::REG_MOTOR_ID_1:  motor_ids_reg[1] <= pwdata[7:0];
                sspp_pkg::REG_MOTOR_ID_2:  motor_ids_reg[2] <= pwdata[7:0];
                sspp_pkg::REG_MOTOR_ID_3:  motor_ids_reg[3] <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            sspp_pkg::REG_MOTOR_COUNT: prdata = {29'd0, motor_count_reg};
            sspp_pkg::REG_MOTOR_ID_0:  prdata = {24'd0, motor_ids_reg[0]};
            sspp_pkg::REG_MOTOR_ID_1:  prdata = {24'd0, motor_ids_reg[1]};
            sspp_pkg::REG_MOTOR_ID_2:  prdata = {24'd0, motor_ids_reg[2]};
            sspp_pkg::REG_MOTOR_ID_3:  prdata = {24'd0, motor_ids_reg[3]};
            default:                   prdata = '0;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    sspp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (s_axis_tuser[0]),
        .data_byte   (s_axis_tdata),
        .motor_count (motor_count_reg),
        .motor_ids   (motor_ids_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    sspp_obuf u_obuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tuser = out_data.status;
    assign m_axis_tdata = {6'd0, out_data.motor_error, out_data.position,
                           out_data.motor_id, out_data.motor_index};

endmodule
